@@ rtl/core/qte_pkg.sv @@
// ============================================================================
// qte_pkg: shared types and constants for the quaternion to Euler angle unit
// Operand widths, stage payload structs and the CORDIC arctangent table.
// ============================================================================
package qte_pkg;

	localparam int QUAT_W         = 16;
	localparam int QUAT_FRAC_BITS = 14;
	localparam int ANGLE_W        = 16;
	localparam int PITCH_W        = 15;
	localparam int OPND_W         = 35;
	localparam int MAG_W          = 34;
	localparam int ANG_W          = 28;
	localparam int ROOT_W         = 62;
	localparam int S30_W          = 32;
	localparam int S30_SHIFT      = 30 - 2 * QUAT_FRAC_BITS;
	localparam int SQRT_STEPS     = 31;
	localparam int NORM_CELLS     = 7;
	localparam int ANGLE_TABLE_LEN = 24;
	localparam int PI_Q13         = 25736;
	localparam int HALF_PI_Q13    = 12868;

	typedef logic signed [OPND_W-1:0] opnd_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic signed [ANG_W-1:0]  ang_t;
	typedef logic [ROOT_W-1:0]        root_t;
	typedef logic signed [S30_W-1:0]  s30_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;

	localparam opnd_t QUAT_ONE    = opnd_t'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
	localparam ang_t  HALF_PI_A24 = 28'sd26353589;

	typedef struct packed {
		opnd_t x;
		opnd_t y;
		mag_t  mag;
		logic  zero;
	} norm_t;

	typedef struct packed {
		opnd_t x;
		opnd_t y;
		ang_t  ang;
		logic  zero;
	} rot_t;

	typedef struct packed {
		root_t rem;
		root_t root;
	} sqrt_t;

	typedef struct packed {
		opnd_t roll_y;
		opnd_t roll_x;
		opnd_t yaw_y;
		opnd_t yaw_x;
		s30_t  s30;
		logic  clamp;
	} side_t;

	// atan(2^-i) with 24 fraction bits
	function automatic ang_t atan_a24(input int step);
		case (step)
			0:  return 28'sd13176795;
			1:  return 28'sd7778716;
			2:  return 28'sd4110060;
			3:  return 28'sd2086331;
			4:  return 28'sd1047214;
			5:  return 28'sd524117;
			6:  return 28'sd262123;
			7:  return 28'sd131069;
			8:  return 28'sd65536;
			9:  return 28'sd32768;
			10: return 28'sd16384;
			11: return 28'sd8192;
			12: return 28'sd4096;
			13: return 28'sd2048;
			14: return 28'sd1024;
			15: return 28'sd512;
			16: return 28'sd256;
			17: return 28'sd128;
			18: return 28'sd64;
			19: return 28'sd32;
			20: return 28'sd16;
			21: return 28'sd8;
			22: return 28'sd4;
			23: return 28'sd2;
			default: return '0;
		endcase
	endfunction

endpackage

@@ rtl/core/qte_sqrt_cell.sv @@
// ============================================================================
// qte_sqrt_cell: one digit of the integer square root
// Trial subtract of root plus the current bit; hands remainder and root on.
// ============================================================================
module qte_sqrt_cell #(
	parameter int BIT_POS = 0
) (
	input  logic           clk,
	input  logic           adv,
	input  qte_pkg::sqrt_t din,
	output qte_pkg::sqrt_t dout
);
	import qte_pkg::*;

	localparam root_t BIT_VAL = root_t'(1) << BIT_POS;

	root_t trial;
	sqrt_t nxt;
	sqrt_t cell_s1;

	always_comb begin
		trial = din.root + BIT_VAL;
		if (din.rem >= trial) begin
			nxt.rem  = din.rem - trial;
			nxt.root = (din.root >> 1) + BIT_VAL;
		end else begin
			nxt.rem  = din.rem;
			nxt.root = din.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_s1 <= nxt;
		end
	end

	assign dout = cell_s1;

endmodule

@@ rtl/core/qte_norm_cell.sv @@
// ============================================================================
// qte_norm_cell: one step of the atan2 operand normalizer
// Shifts the vector by a fixed amount when the magnitude calls for it.
// ============================================================================
module qte_norm_cell #(
	parameter bit LEFT = 1'b1,
	parameter int AMT  = 1
) (
	input  logic           clk,
	input  logic           adv,
	input  qte_pkg::norm_t din,
	output qte_pkg::norm_t dout
);
	import qte_pkg::*;

	localparam mag_t THRESH = LEFT ? (mag_t'(1) << (30 - AMT)) : (mag_t'(1) << (29 + AMT));

	logic  hit;
	opnd_t x;
	opnd_t y;
	norm_t nxt;
	norm_t cell_s1;

	always_comb begin
		x   = din.x;
		y   = din.y;
		hit = LEFT ? (din.mag < THRESH) : (din.mag >= THRESH);
		nxt = din;
		if (hit) begin
			if (LEFT) begin
				nxt.x   = x <<< AMT;
				nxt.y   = y <<< AMT;
				nxt.mag = din.mag << AMT;
			end else begin
				// floor shift, matches rounding toward minus infinity
				nxt.x   = x >>> AMT;
				nxt.y   = y >>> AMT;
				nxt.mag = din.mag >> AMT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_s1 <= nxt;
		end
	end

	assign dout = cell_s1;

endmodule

@@ rtl/core/qte_rot_cell.sv @@
// ============================================================================
// qte_rot_cell: one CORDIC vectoring micro-rotation
// Rotates toward the x axis and accumulates the table angle.
// ============================================================================
module qte_rot_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          adv,
	input  qte_pkg::rot_t din,
	output qte_pkg::rot_t dout
);
	import qte_pkg::*;

	localparam ang_t ATAN = atan_a24(STEP);

	opnd_t x;
	opnd_t y;
	opnd_t xs;
	opnd_t ys;
	rot_t  nxt;
	rot_t  cell_s1;

	always_comb begin
		x  = din.x;
		y  = din.y;
		xs = x >>> STEP;
		ys = y >>> STEP;
		nxt.zero = din.zero;
		if (!y[OPND_W-1]) begin
			nxt.x   = x + ys;
			nxt.y   = y - xs;
			nxt.ang = din.ang + ATAN;
		end else begin
			nxt.x   = x - ys;
			nxt.y   = y + xs;
			nxt.ang = din.ang - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_s1 <= nxt;
		end
	end

	assign dout = cell_s1;

endmodule

@@ rtl/core/qte_atan2.sv @@
// ============================================================================
// qte_atan2: pipelined atan2 by vectoring CORDIC
// Magnitude, normalize, quadrant pre-rotation, CORDIC row, round and clip.
// ============================================================================
module qte_atan2 #(
	parameter int STEPS = 16,
	parameter int LIMIT = 25736
) (
	input  logic            clk,
	input  logic            adv,
	input  qte_pkg::opnd_t  y_in,
	input  qte_pkg::opnd_t  x_in,
	output qte_pkg::angle_t angle
);
	import qte_pkg::*;

	localparam int RND_W = ANG_W - 11;
	localparam logic signed [RND_W-1:0] LIM_POS = RND_W'(LIMIT);
	localparam logic signed [RND_W-1:0] LIM_NEG = -RND_W'(LIMIT);

	opnd_t ax;
	opnd_t ay;
	mag_t  mx;
	mag_t  my;
	norm_t head_s1;
	norm_t norm_v [0:NORM_CELLS];
	rot_t  pre;
	rot_t  pre_s1;
	rot_t  rot_v [0:STEPS];
	ang_t  biased;
	logic signed [RND_W-1:0] rnd;
	angle_t res;
	angle_t angle_s1;

	always_comb begin
		ax = x_in[OPND_W-1] ? -x_in : x_in;
		ay = y_in[OPND_W-1] ? -y_in : y_in;
		mx = mag_t'(ax);
		my = mag_t'(ay);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			head_s1.x    <= x_in;
			head_s1.y    <= y_in;
			head_s1.mag  <= (mx > my) ? mx : my;
			head_s1.zero <= (x_in == '0) && (y_in == '0);
		end
	end

	assign norm_v[0] = head_s1;

	// two right steps bring the magnitude below 2^31, five left steps lift it to 2^29
	genvar j;
	generate
		for (j = 0; j < NORM_CELLS; j++) begin : g_norm
			qte_norm_cell #(
				.LEFT (j >= 2),
				.AMT  ((j < 2) ? (2 - j) : (1 << (NORM_CELLS - 1 - j)))
			) u_cell (
				.clk  (clk),
				.adv  (adv),
				.din  (norm_v[j]),
				.dout (norm_v[j+1])
			);
		end
	endgenerate

	always_comb begin
		pre.zero = norm_v[NORM_CELLS].zero;
		pre.x    = norm_v[NORM_CELLS].x;
		pre.y    = norm_v[NORM_CELLS].y;
		pre.ang  = '0;
		if (norm_v[NORM_CELLS].x[OPND_W-1]) begin
			if (!norm_v[NORM_CELLS].y[OPND_W-1]) begin
				pre.x   = norm_v[NORM_CELLS].y;
				pre.y   = -norm_v[NORM_CELLS].x;
				pre.ang = HALF_PI_A24;
			end else begin
				pre.x   = -norm_v[NORM_CELLS].y;
				pre.y   = norm_v[NORM_CELLS].x;
				pre.ang = -HALF_PI_A24;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s1 <= pre;
		end
	end

	assign rot_v[0] = pre_s1;

	genvar i;
	generate
		for (i = 0; i < STEPS; i++) begin : g_rot
			qte_rot_cell #(
				.STEP (i)
			) u_cell (
				.clk  (clk),
				.adv  (adv),
				.din  (rot_v[i]),
				.dout (rot_v[i+1])
			);
		end
	endgenerate

	always_comb begin
		biased = rot_v[STEPS].ang + ang_t'(1024);
		rnd    = biased[ANG_W-1:11];
		if (rot_v[STEPS].zero) begin
			res = '0;
		end else if (rnd > LIM_POS) begin
			res = ANGLE_W'(LIM_POS);
		end else if (rnd < LIM_NEG) begin
			res = ANGLE_W'(LIM_NEG);
		end else begin
			res = ANGLE_W'(rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s1 <= res;
		end
	end

	assign angle = angle_s1;

endmodule

@@ rtl/core/quaternion_to_euler_angles_unit.sv @@
// ============================================================================
// quaternion_to_euler_angles_unit: attitude quaternion to roll, pitch, yaw
// Fully pipelined converter with a valid/ready beat on each side.
// ============================================================================
// Input channel: quat_valid/quat_ready carry one Q2.14 quaternion per beat.
// Output channel: euler_valid/euler_ready carry roll, yaw (Q3.13), pitch
// (Q2.13) in radians and pitch_clamped, one beat per input beat, in order.
// Products and sums take three stages, the cosine for pitch is a row of 31
// square-root digit cells, and the three atan2 evaluations run side by side
// through CORDIC_STEPS + 10 stages (normalize, pre-rotate, CORDIC, round).
// Throughput: one beat per cycle unless the output stalls; the row of cells
// is the pipeline. Reset clears every stage valid bit and the output valid
// bit; data stages and the output data registers are not reset. When
// euler_valid is high and euler_ready is low, the whole pipeline holds and
// quat_ready drops; quat_ready is high whenever the output register is
// empty or is being taken in the same cycle.
// ============================================================================
module quaternion_to_euler_angles_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             quat_valid,
	output logic                             quat_ready,
	input  logic signed [15:0]               quat_w,
	input  logic signed [15:0]               quat_x,
	input  logic signed [15:0]               quat_y,
	input  logic signed [15:0]               quat_z,
	output logic                             euler_valid,
	input  logic                             euler_ready,
	output logic signed [15:0]               roll_angle,
	output logic signed [14:0]               pitch_angle,
	output logic signed [15:0]               yaw_angle,
	output logic                             pitch_clamped
);
	import qte_pkg::*;

	localparam int ATAN_LAT = CORDIC_STEPS + 10;
	localparam int LAT      = 3 + SQRT_STEPS + ATAN_LAT;

	logic adv;
	logic [LAT-1:0] vld_q;
	logic out_v_q;

	logic signed [2*QUAT_W-1:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wz_s1;
	logic signed [2*QUAT_W-1:0] p_xy_s1, p_zz_s1, p_wy_s1, p_zx_s1;

	opnd_t sdiff;
	side_t side;
	side_t side_s2;
	side_t side_s3;
	side_t side_dly_q [0:SQRT_STEPS-1];
	side_t side_out;

	logic [S30_W-2:0] s_mag;
	root_t            s_sq;
	sqrt_t            sqrt_s3;
	sqrt_t            sqrt_v [0:SQRT_STEPS];

	logic [ATAN_LAT-1:0] clamp_dly_q;

	angle_t roll_a;
	angle_t pitch_a;
	angle_t yaw_a;

	angle_t roll_q;
	logic signed [PITCH_W-1:0] pitch_q;
	angle_t yaw_q;
	logic clamp_q;

	assign adv        = !out_v_q || euler_ready;
	assign quat_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			vld_q   <= {vld_q[LAT-2:0], quat_valid};
			out_v_q <= vld_q[LAT-1];
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (adv) begin
			p_wx_s1 <= quat_w * quat_x;
			p_yz_s1 <= quat_y * quat_z;
			p_xx_s1 <= quat_x * quat_x;
			p_yy_s1 <= quat_y * quat_y;
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_zz_s1 <= quat_z * quat_z;
			p_wy_s1 <= quat_w * quat_y;
			p_zx_s1 <= quat_z * quat_x;
		end
	end

	// stage 2: atan2 operands and the saturated asin argument
	always_comb begin
		side.roll_y = (opnd_t'(p_wx_s1) + opnd_t'(p_yz_s1)) <<< 1;
		side.roll_x = QUAT_ONE - ((opnd_t'(p_xx_s1) + opnd_t'(p_yy_s1)) <<< 1);
		side.yaw_y  = (opnd_t'(p_wz_s1) + opnd_t'(p_xy_s1)) <<< 1;
		side.yaw_x  = QUAT_ONE - ((opnd_t'(p_yy_s1) + opnd_t'(p_zz_s1)) <<< 1);
		sdiff       = (opnd_t'(p_wy_s1) - opnd_t'(p_zx_s1)) <<< 1;
		side.clamp  = 1'b0;
		if (sdiff > QUAT_ONE) begin
			sdiff      = QUAT_ONE;
			side.clamp = 1'b1;
		end else if (sdiff < -QUAT_ONE) begin
			sdiff      = -QUAT_ONE;
			side.clamp = 1'b1;
		end
		side.s30 = s30_t'(sdiff <<< S30_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side;
		end
	end

	// stage 3: radicand 2^60 - s^2
	always_comb begin
		s_mag = side_s2.s30[S30_W-1] ? (S30_W-1)'(-side_s2.s30) : (S30_W-1)'(side_s2.s30);
		s_sq  = s_mag * s_mag;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3      <= side_s2;
			sqrt_s3.rem  <= (root_t'(1) << 60) - s_sq;
			sqrt_s3.root <= '0;
		end
	end

	assign sqrt_v[0] = sqrt_s3;

	genvar i;
	generate
		for (i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
			qte_sqrt_cell #(
				.BIT_POS (60 - 2 * i)
			) u_cell (
				.clk  (clk),
				.adv  (adv),
				.din  (sqrt_v[i]),
				.dout (sqrt_v[i+1])
			);
		end
	endgenerate

	// hold roll/yaw operands alongside the square-root row
	always_ff @(posedge clk) begin
		if (adv) begin
			side_dly_q[0] <= side_s3;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				side_dly_q[k] <= side_dly_q[k-1];
			end
		end
	end

	assign side_out = side_dly_q[SQRT_STEPS-1];

	qte_atan2 #(
		.STEPS (CORDIC_STEPS),
		.LIMIT (PI_Q13)
	) u_roll (
		.clk   (clk),
		.adv   (adv),
		.y_in  (side_out.roll_y),
		.x_in  (side_out.roll_x),
		.angle (roll_a)
	);

	qte_atan2 #(
		.STEPS (CORDIC_STEPS),
		.LIMIT (HALF_PI_Q13)
	) u_pitch (
		.clk   (clk),
		.adv   (adv),
		.y_in  (opnd_t'(side_out.s30)),
		.x_in  (opnd_t'(sqrt_v[SQRT_STEPS].root)),
		.angle (pitch_a)
	);

	qte_atan2 #(
		.STEPS (CORDIC_STEPS),
		.LIMIT (PI_Q13)
	) u_yaw (
		.clk   (clk),
		.adv   (adv),
		.y_in  (side_out.yaw_y),
		.x_in  (side_out.yaw_x),
		.angle (yaw_a)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			clamp_dly_q <= {clamp_dly_q[ATAN_LAT-2:0], side_out.clamp};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			roll_q  <= roll_a;
			pitch_q <= pitch_a[PITCH_W-1:0];
			yaw_q   <= yaw_a;
			clamp_q <= clamp_dly_q[ATAN_LAT-1];
		end
	end

	assign euler_valid   = out_v_q;
	assign roll_angle    = roll_q;
	assign pitch_angle   = pitch_q;
	assign yaw_angle     = yaw_q;
	assign pitch_clamped = clamp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736))
		else $error("roll beat outside +-pi");

	assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid |-> (yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736))
		else $error("yaw beat outside +-pi");

	assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid |-> (pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868))
		else $error("pitch beat outside +-pi/2");

	assert property (@(posedge clk) disable iff (!arst_n)
		!quat_ready |-> (euler_valid && !euler_ready))
		else $error("input stalled without a held output beat");

endmodule
